@@ rtl/flash_cluster_span_index_assert.svh @@
`ifndef FLASH_CLUSTER_SPAN_INDEX_ASSERT_SVH
`define FLASH_CLUSTER_SPAN_INDEX_ASSERT_SVH

// same-cycle implication, checked on aclk outside reset
`define FCSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define FCSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fcsi_pkg.sv @@
`timescale 1ns / 1ps

package fcsi_pkg;

    localparam int BLK_W = 12;
    localparam int ID_W  = 16;

    localparam logic [ID_W-1:0] ID_NONE = 16'hFFFF;

    // action codes
    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_WRAP   = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;

    // stream type code with no spans
    localparam logic [1:0] TYPE_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OUTSIDE = 2'd1;
    localparam logic [1:0] STAT_MISS    = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  first_id;
        logic [ID_W-1:0]  last_id;
        logic [BLK_W-1:0] first_blk;
        logic [BLK_W-1:0] last_blk;
    } span_t;

    // one memory row: both spans of one cluster and one stream type
    typedef struct packed {
        span_t s1;
        span_t s0;
    } row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MAP,
        ST_UPD,
        ST_LOOK,
        ST_OUT
    } state_t;

endpackage

@@ rtl/flash_cluster_span_index.sv @@
`timescale 1ns / 1ps
`include "flash_cluster_span_index_assert.svh"

// flash cluster span index
// the recording area starts at base_block and is cut into CLUSTERS clusters
// of CLUSTER_BLOCKS blocks; for each cluster and each of the three stream
// types the block keeps two spans (first/last fragment id, first/last block)
// in one memory row. every input word yields exactly one result word, and
// s_tready stays low from acceptance until the cycle after the result
// register is loaded. the steps from acceptance to the result register:
//   record into cluster c: the shared compare/subtract unit takes the block
//     offset down by CLUSTER_BLOCKS once per cycle, c subtract steps plus
//     one final compare, then map and read the row, a read-modify-write and
//     the output state (stream type 3 skips the read and the update)
//   record beyond the last cluster: subtract steps until the quotient reaches
//     CLUSTERS, one final compare, map, output
//   wrap mark, unused action, record below base_block, lookup of type 3:
//     straight to the output state
//   lookup: one row read per cluster through the single memory read port,
//     the first hit ends the walk, a miss reads the rows of all clusters
// the output state waits while the previous result is held by m_tready.
// after reset a clearing pass writes all CLUSTERS*3 rows, one per cycle, and
// no word is accepted until it ends; base_block writes are taken at any time
// but belong in idle periods. the result register lets a new word in while
// the previous result still waits on m_tready.
module flash_cluster_span_index #(
    parameter int CLUSTERS       = 16,
    parameter int CLUSTER_BLOCKS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // base_block register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,     // base_block

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // block_number [11:0], frag_id [27:12], zero fill
    input  logic [3:0]  s_tuser,      // action [1:0], stream_type [3:2]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // cluster_index [3:0], span_hit [4], zero fill
    output logic [1:0]  m_tuser       // status [1:0]
);

    import fcsi_pkg::*;

    localparam int ROWS     = CLUSTERS * 3;
    localparam int AW       = $clog2(ROWS);
    localparam int CW       = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int KW       = $clog2(CLUSTERS + 1);
    localparam int ROW_W    = $bits(row_t);

    localparam logic [AW-1:0]    LAST_ROW = AW'(ROWS - 1);
    localparam logic [BLK_W-1:0] BLK_STEP = BLK_W'(CLUSTER_BLOCKS);
    localparam logic [KW-1:0]    K_END    = KW'(CLUSTERS);

    // control and item registers
    state_t           state_reg, state_next;
    logic [11:0]      base_reg, base_next;
    logic [2:0]       wrap_reg, wrap_next;
    logic [1:0]       act_reg, act_next;
    logic [1:0]       typ_reg, typ_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [ID_W-1:0]  id_reg, id_next;

    // clearing pass and row walk
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [AW-1:0]    row_addr_reg, row_addr_next;
    logic [KW-1:0]    look_k_reg, look_k_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [CW-1:0]    chk_k_reg, chk_k_next;

    // shared compare/subtract unit for the cluster number
    logic [BLK_W-1:0] off_reg, off_next;
    logic [KW-1:0]    quo_reg, quo_next;

    // pending result and output register
    logic [1:0]       res_status_reg, res_status_next;
    logic [3:0]       res_cl_reg, res_cl_next;
    logic             res_hit_reg, res_hit_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [3:0]       m_cl_reg, m_cl_next;
    logic             m_hit_reg, m_hit_next;

    // memory port
    logic             ram_we;
    logic [AW-1:0]    ram_wr_addr;
    row_t             ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    row_t             ram_rd_data;

    // input word fields
    logic [1:0]       in_action;
    logic [BLK_W-1:0] in_block;
    logic [ID_W-1:0]  in_id;
    logic [1:0]       in_type;

    // combinational helpers
    logic             accept;
    logic             out_free;
    logic [2:0]       wrap_bit;
    logic             div_more;
    logic             cl_ok;
    logic [AW-1:0]    map_addr;
    logic             hold0, hold1;
    logic             look_hit;
    logic             look_miss;

    assign in_action = s_tuser[1:0];
    assign in_type   = s_tuser[3:2];
    assign in_block  = s_tdata[11:0];
    assign in_id     = s_tdata[27:12];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_status_reg;
    assign m_tdata   = {3'b000, m_hit_reg, m_cl_reg};

    function automatic logic span_holds(span_t sp, logic [ID_W-1:0] id);
        return (sp.first_id != ID_NONE) && (id >= sp.first_id) && (id <= sp.last_id);
    endfunction

    function automatic span_t span_open(logic [ID_W-1:0] id, logic [BLK_W-1:0] blk);
        span_t sp;
        sp.first_id  = id;
        sp.last_id   = id;
        sp.first_blk = blk;
        sp.last_blk  = blk;
        return sp;
    endfunction

    // record rules: restart, open span 0, extend span 0, open span 1,
    // extend span 1 and promote it once it reaches span 0
    function automatic row_t span_update(row_t r, logic wrap, logic [ID_W-1:0] id,
                                         logic [BLK_W-1:0] blk);
        row_t  n;
        span_t t;
        n = r;
        t = r.s1;
        if (wrap) begin
            n.s0          = span_open(id, blk);
            n.s1.first_id = ID_NONE;
            n.s1.last_id  = ID_NONE;
        end else if (r.s0.first_id == ID_NONE) begin
            n.s0 = span_open(id, blk);
        end else if (r.s0.last_blk <= blk && r.s1.first_id == ID_NONE) begin
            n.s0.last_id  = id;
            n.s0.last_blk = blk;
        end else if (r.s1.first_id == ID_NONE) begin
            n.s1 = span_open(id, blk);
        end else begin
            if (t.last_blk <= blk) begin
                t.last_id  = id;
                t.last_blk = blk;
            end
            n.s1 = t;
            if (t.last_blk >= r.s0.last_blk) begin
                // promotion keeps span 1 blocks, empties its ids
                n.s0          = t;
                n.s1.first_id = ID_NONE;
                n.s1.last_id  = ID_NONE;
            end
        end
        return n;
    endfunction

    assign wrap_bit  = 3'(3'b001 << typ_reg);
    // another whole cluster fits below the offset and the area is not passed yet
    assign div_more  = (off_reg >= BLK_STEP) && (quo_reg != K_END);
    assign cl_ok     = (quo_reg != K_END);
    assign map_addr  = (AW'(quo_reg[CW-1:0]) << 1) + AW'(quo_reg[CW-1:0]) + AW'(typ_reg);
    assign hold0     = span_holds(ram_rd_data.s0, id_reg);
    assign hold1     = span_holds(ram_rd_data.s1, id_reg);
    assign look_hit  = chk_vld_reg && (hold0 || hold1);
    // the last cluster's row has been read and missed
    assign look_miss = !look_hit && (look_k_reg == K_END);

    fcsi_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_span_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_action == ACT_RECORD) begin
                        state_next = (in_block < base_reg) ? ST_OUT : ST_DIV;
                    end else if (in_action == ACT_LOOKUP) begin
                        state_next = (in_type == TYPE_UNUSED) ? ST_OUT : ST_LOOK;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (!div_more) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                state_next = (cl_ok && typ_reg != TYPE_UNUSED) ? ST_UPD : ST_OUT;
            end
            ST_UPD: begin
                state_next = ST_OUT;
            end
            ST_LOOK: begin
                if (look_hit || look_miss) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        base_next       = base_reg;
        wrap_next       = wrap_reg;
        act_next        = act_reg;
        typ_next        = typ_reg;
        blk_next        = blk_reg;
        id_next         = id_reg;
        clr_addr_next   = clr_addr_reg;
        row_addr_next   = row_addr_reg;
        look_k_next     = look_k_reg;
        chk_vld_next    = chk_vld_reg;
        chk_k_next      = chk_k_reg;
        off_next        = off_reg;
        quo_next        = quo_reg;
        res_status_next = res_status_reg;
        res_cl_next     = res_cl_reg;
        res_hit_next    = res_hit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_cl_next       = m_cl_reg;
        m_hit_next      = m_hit_reg;
        ram_we          = 1'b0;
        ram_wr_addr     = row_addr_reg;
        ram_wr_data     = span_update(ram_rd_data, (wrap_reg & wrap_bit) != 3'b000,
                                      id_reg, blk_reg);
        ram_rd_en       = 1'b0;
        ram_rd_addr     = row_addr_reg;

        if (cfg_valid) begin
            base_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we                = 1'b1;
                ram_wr_addr           = clr_addr_reg;
                ram_wr_data.s0        = span_open(ID_NONE, '0);
                ram_wr_data.s1        = span_open(ID_NONE, '0);
                clr_addr_next         = clr_addr_reg + AW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    act_next        = in_action;
                    typ_next        = in_type;
                    blk_next        = in_block;
                    id_next         = in_id;
                    off_next        = in_block - base_reg;
                    quo_next        = '0;
                    row_addr_next   = AW'(in_type);
                    look_k_next     = '0;
                    chk_vld_next    = 1'b0;
                    res_status_next = STAT_OK;
                    res_cl_next     = '0;
                    res_hit_next    = 1'b0;
                    if (in_action == ACT_RECORD && in_block < base_reg) begin
                        res_status_next = STAT_OUTSIDE;
                    end
                    if (in_action == ACT_LOOKUP) begin
                        res_status_next = STAT_MISS;
                    end
                    if (in_action == ACT_WRAP && in_type != TYPE_UNUSED) begin
                        wrap_next = wrap_reg | 3'(3'b001 << in_type);
                    end
                end
            end
            ST_DIV: begin
                if (div_more) begin
                    off_next = off_reg - BLK_STEP;
                    quo_next = quo_reg + KW'(1);
                end
            end
            ST_MAP: begin
                if (!cl_ok) begin
                    res_status_next = STAT_OUTSIDE;
                end else begin
                    res_cl_next   = 4'(quo_reg[CW-1:0]);
                    row_addr_next = map_addr;
                    ram_rd_addr   = map_addr;
                    ram_rd_en     = (typ_reg != TYPE_UNUSED);
                end
            end
            ST_UPD: begin
                ram_we    = 1'b1;
                wrap_next = wrap_reg & ~wrap_bit;
            end
            ST_LOOK: begin
                if (look_hit) begin
                    res_status_next = STAT_OK;
                    res_cl_next     = 4'(chk_k_reg);
                    res_hit_next    = !hold0;
                end else if (!look_miss) begin
                    ram_rd_en     = 1'b1;
                    row_addr_next = row_addr_reg + AW'(3);
                    look_k_next   = look_k_reg + KW'(1);
                    chk_vld_next  = 1'b1;
                    chk_k_next    = look_k_reg[CW-1:0];
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_cl_next     = res_cl_reg;
                    m_hit_next    = res_hit_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            base_reg     <= '0;
            wrap_reg     <= '0;
            clr_addr_reg <= '0;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            wrap_reg     <= wrap_next;
            clr_addr_reg <= clr_addr_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        typ_reg        <= typ_next;
        blk_reg        <= blk_next;
        id_reg         <= id_next;
        row_addr_reg   <= row_addr_next;
        look_k_reg     <= look_k_next;
        chk_k_reg      <= chk_k_next;
        off_reg        <= off_next;
        quo_reg        <= quo_next;
        res_status_reg <= res_status_next;
        res_cl_reg     <= res_cl_next;
        res_hit_reg    <= res_hit_next;
        m_status_reg   <= m_status_next;
        m_cl_reg       <= m_cl_next;
        m_hit_reg      <= m_hit_next;
    end

    // a new result word only ever comes out of the output state
    `FCSI_ASSERT_NOW(a_result_from_out, $rose(m_tvalid_reg),
        $past(state_reg) == ST_OUT, "result word outside output state")
    // a failed record or lookup never reports a cluster or span
    `FCSI_ASSERT_NOW(a_fail_zero_fields, m_tvalid_reg && m_status_reg != STAT_OK,
        m_cl_reg == 4'd0 && !m_hit_reg, "nonzero fields with failing status")
    // the lookup walk leaves the wrap marks alone
    `FCSI_ASSERT_NEXT(a_look_keeps_wrap, state_reg == ST_LOOK, $stable(wrap_reg),
        "wrap marks changed during lookup")
    // only the clearing pass and the record update write the span memory
    `FCSI_ASSERT_NOW(a_ram_write_src, ram_we, state_reg == ST_CLEAR || state_reg == ST_UPD,
        "span memory written outside clear or update")
    // wrap words answer with an all-zero result; unused action words do as well, but only wrap words are checked here
    `FCSI_ASSERT_NOW(a_wrap_result, state_reg == ST_OUT && act_reg == ACT_WRAP,
        res_status_reg == STAT_OK && res_cl_reg == 4'd0 && !res_hit_reg,
        "wrap result not zero")

endmodule

@@ rtl/fcsi_ram.sv @@
`timescale 1ns / 1ps

module fcsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
